/* rtl/vrw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrw_pkg: shared types and constants of the voxel ray walker
// hit and update payloads, register file layout, ray descriptor
// ----------------------------------------------------------------------------
package vrw_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_INV_RES   = 3'd0;
	localparam logic [2:0] CFG_STEPS     = 3'd1;
	localparam logic [2:0] CFG_RANGE_EN  = 3'd2;
	localparam logic [2:0] CFG_RANGE_LIM = 3'd3;
	localparam logic [2:0] CFG_LO_FREE   = 3'd4;
	localparam logic [2:0] CFG_LO_OCC    = 3'd5;
	localparam logic [2:0] CFG_LO_UNK    = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// reset values
	localparam logic [15:0] RST_INV_RES   = 16'd1280;
	localparam logic [6:0]  RST_STEPS     = 7'd64;
	localparam logic        RST_RANGE_EN  = 1'b0;
	localparam logic [14:0] RST_RANGE_LIM = 15'd32767;
	localparam logic [15:0] RST_LO_FREE   = 16'hFF9A;
	localparam logic [15:0] RST_LO_OCC    = 16'd218;
	localparam logic [15:0] RST_LO_UNK    = 16'd0;

	// widths of the walk datapath
	localparam int VOX_W  = 16;
	localparam int AD_W   = 17;
	localparam int CUR_W  = 17;
	localparam int ERR_W  = 19;
	localparam int PROD_W = 41;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam int RAY_Q_DEPTH = 2;

	typedef struct packed {
		logic signed [23:0] hit_x;
		logic signed [23:0] hit_y;
		logic signed [23:0] hit_z;
	} hit_t;

	typedef struct packed {
		logic signed [15:0] voxel_x;
		logic signed [15:0] voxel_y;
		logic signed [15:0] voxel_z;
		logic signed [15:0] log_odds_update;
		logic               last;
	} upd_t;

	typedef struct packed {
		logic [15:0]        inv_resolution;
		logic [6:0]         ray_slots;
		logic               range_check_enable;
		logic [14:0]        range_limit;
		logic signed [15:0] log_odds_free;
		logic signed [15:0] log_odds_occupied;
		logic signed [15:0] log_odds_unknown;
	} cfg_t;

	// one classified ray, handed from front to back
	typedef struct packed {
		logic [2:0][VOX_W-1:0] vend;
		logic [2:0][AD_W-1:0]  ad;
		logic [2:0][ERR_W-1:0] err;
		logic [1:0]            dom;
		logic                  end_oor;
	} ray_t;

endpackage
`default_nettype wire

/* rtl/voxel_ray_walk_log_odds.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_ray_walk_log_odds: sensor ray walker with log-odds updates
// quantizes each hit point to a voxel and walks a 3d bresenham line from
// the origin voxel, emitting one update per voxel slot
// ----------------------------------------------------------------------------
// Each hit request produces exactly ray_slots (clamped to 1..MAX_STEPS)
// update requests on the upd channel, the last one flagged with last and
// carrying the end voxel. The front quantizes and classifies hits in a
// two-stage pipeline and parks them in a two-entry ray queue, so new hits
// are taken while a ray is still being walked. The walker handles one ray
// at a time and takes the next only when it is done: it loads the ray, then
// takes one walk step per result slot and per walk voxel dropped by the
// range check, holding while the update consumer is not ready. The walker
// step (one bresenham update of three error terms) is the unit of the walk.
// Configuration writes take effect at once and must only happen while idle.
module voxel_ray_walk_log_odds #(
	parameter int MAX_STEPS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// hit requests
	input  wire logic                             hit_valid,
	output logic                                  hit_ready,
	input  wire vrw_pkg::hit_t                    hit,
	// update requests
	output logic                                  upd_valid,
	input  wire logic                             upd_ready,
	output vrw_pkg::upd_t                         upd,
	// register writes
	input  wire logic                             cfg_wr_en,
	input  wire logic [vrw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vrw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vrw_pkg::*;

	cfg_t cfg_q;

	// front to queue
	logic fq_valid;
	logic fq_ready;
	ray_t fq_ray;
	// queue to walker
	logic qb_valid;
	logic qb_ready;
	ray_t qb_ray;

	// register file, fields narrowed to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_resolution     <= RST_INV_RES;
			cfg_q.ray_slots          <= RST_STEPS;
			cfg_q.range_check_enable <= RST_RANGE_EN;
			cfg_q.range_limit        <= RST_RANGE_LIM;
			cfg_q.log_odds_free      <= RST_LO_FREE;
			cfg_q.log_odds_occupied  <= RST_LO_OCC;
			cfg_q.log_odds_unknown   <= RST_LO_UNK;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_INV_RES:   cfg_q.inv_resolution     <= cfg_data;
				CFG_STEPS:     cfg_q.ray_slots          <= cfg_data[6:0];
				CFG_RANGE_EN:  cfg_q.range_check_enable <= cfg_data[0];
				CFG_RANGE_LIM: cfg_q.range_limit        <= cfg_data[14:0];
				CFG_LO_FREE:   cfg_q.log_odds_free      <= cfg_data;
				CFG_LO_OCC:    cfg_q.log_odds_occupied  <= cfg_data;
				CFG_LO_UNK:    cfg_q.log_odds_unknown   <= cfg_data;
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// quantize and classify
	vrw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit       (hit),
		.ray_valid (fq_valid),
		.ray_ready (fq_ready),
		.ray       (fq_ray)
	);

	// ray queue between front and walker
	vrw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_ray),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_ray)
	);

	// bresenham walk and result stage
	vrw_back #(
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ray_valid (qb_valid),
		.ray_ready (qb_ready),
		.ray       (qb_ray),
		.upd_valid (upd_valid),
		.upd_ready (upd_ready),
		.upd       (upd)
	);

endmodule
`default_nettype wire

/* rtl/vrw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrw_front: hit quantizer and ray classifier
// multiply by inverse resolution, round, saturate, pick dominant axis
// ----------------------------------------------------------------------------
module vrw_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vrw_pkg::cfg_t cfg,
	input  wire logic          hit_valid,
	output logic               hit_ready,
	input  wire vrw_pkg::hit_t hit,
	output logic               ray_valid,
	input  wire logic          ray_ready,
	output vrw_pkg::ray_t      ray
);
	import vrw_pkg::*;

	logic                     valid_s1;
	logic [2:0][PROD_W-1:0]   prod_s1;
	logic                     valid_s2;
	logic [2:0][VOX_W-1:0]    amag_s2;
	logic [2:0][VOX_W-1:0]    vend_s2;

	logic                     adv1;
	logic                     adv2;
	logic signed [PROD_W-1:0] prod_w [3];
	logic [2:0][VOX_W-1:0]    amag_w;
	logic [2:0][VOX_W-1:0]    vend_w;

	assign adv2      = !valid_s2 || ray_ready;
	assign adv1      = !valid_s1 || adv2;
	assign hit_ready = adv1;
	assign ray_valid = valid_s2;

	// signed hit times unsigned Q8.8 scale
	always_comb begin
		prod_w[0] = $signed(hit.hit_x) * $signed({1'b0, cfg.inv_resolution});
		prod_w[1] = $signed(hit.hit_y) * $signed({1'b0, cfg.inv_resolution});
		prod_w[2] = $signed(hit.hit_z) * $signed({1'b0, cfg.inv_resolution});
	end

	// round half away from zero, then saturate to 16 bits
	always_comb begin
		logic              neg;
		logic [PROD_W-1:0] rnd;
		logic [24:0]       q;
		for (int i = 0; i < 3; i++) begin
			neg = prod_s1[i][PROD_W-1];
			rnd = neg ? (PROD_W'(32'h8000) - prod_s1[i]) : (prod_s1[i] + PROD_W'(32'h8000));
			q   = rnd[PROD_W-1:16];
			if (neg) begin
				amag_w[i] = (q > 25'd32768) ? 16'h8000 : q[15:0];
				vend_w[i] = 16'd0 - amag_w[i];
			end else begin
				amag_w[i] = (q > 25'd32767) ? 16'h7FFF : q[15:0];
				vend_w[i] = amag_w[i];
			end
		end
	end

	// dominant axis, initial error terms, end range test
	always_comb begin
		logic [1:0]       dom01;
		logic [VOX_W-1:0] max01;
		logic [VOX_W-1:0] amag_dom;
		logic             oor;
		dom01 = (amag_s2[1] > amag_s2[0]) ? AXIS_Y : AXIS_X;
		max01 = (amag_s2[1] > amag_s2[0]) ? amag_s2[1] : amag_s2[0];
		ray.dom = (amag_s2[2] > max01) ? AXIS_Z : dom01;
		amag_dom = (amag_s2[2] > max01) ? amag_s2[2] : max01;
		oor = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ray.ad[i]  = {amag_s2[i], 1'b0};
			ray.err[i] = ERR_W'({amag_s2[i], 1'b0}) - ERR_W'(amag_dom);
			if (amag_s2[i] > {1'b0, cfg.range_limit})
				oor = 1'b1;
		end
		ray.end_oor = cfg.range_check_enable && oor;
		ray.vend    = vend_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= hit_valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && hit_valid) begin
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= prod_w[i];
		end
		if (adv2 && valid_s1) begin
			amag_s2 <= amag_w;
			vend_s2 <= vend_w;
		end
	end

`ifndef SYNTHESIS
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ray_ready |=> valid_s2 && $stable(vend_s2) && $stable(amag_s2))
		else $error("front stage two changed while stalled");
`endif

endmodule
`default_nettype wire

/* rtl/vrw_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrw_fifo: short ray queue
// decouples the quantizer from the walker
// ----------------------------------------------------------------------------
module vrw_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire vrw_pkg::ray_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output vrw_pkg::ray_t      out_data
);
	import vrw_pkg::*;

	localparam int PTR_W = (RAY_Q_DEPTH > 1) ? $clog2(RAY_Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(RAY_Q_DEPTH + 1);

	ray_t             mem_q [RAY_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != CNT_W'(RAY_Q_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RAY_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RAY_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_data;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RAY_Q_DEPTH))
		else $error("ray queue count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("ray queue lost a push");
`endif

endmodule
`default_nettype wire

/* rtl/vrw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrw_back: bresenham walker
// one walk step per cycle unless the output stage is stalled, results through a registered output stage
// ----------------------------------------------------------------------------
module vrw_back #(
	parameter int MAX_STEPS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vrw_pkg::cfg_t cfg,
	input  wire logic          ray_valid,
	output logic               ray_ready,
	input  wire vrw_pkg::ray_t ray,
	output logic               upd_valid,
	input  wire logic          upd_ready,
	output vrw_pkg::upd_t      upd
);
	import vrw_pkg::*;

	localparam int KW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	logic                  busy_q;
	logic [KW-1:0]         k_q;
	logic [2:0][VOX_W-1:0] vend_q;
	logic [2:0][AD_W-1:0]  ad_q;
	logic [2:0][ERR_W-1:0] err_q;
	logic [1:0]            dom_q;
	logic                  end_oor_q;
	logic [2:0][CUR_W-1:0] cur_q;
	upd_t                  out_q;
	logic                  out_valid_q;

	logic                  load;
	logic                  adv;
	logic [6:0]            slots_m1;
	logic                  at_end;
	logic [CUR_W-1:0]      cur_dom;
	logic [CUR_W-1:0]      end_dom;
	logic [AD_W-1:0]       ad_dom;
	logic                  reached;
	logic                  cur_oor;
	logic                  emit;
	upd_t                  res;
	logic [2:0][CUR_W-1:0] cur_d;
	logic [2:0][ERR_W-1:0] err_d;

	assign ray_ready = !busy_q;
	assign load      = ray_valid && !busy_q;
	assign adv       = busy_q && (!out_valid_q || upd_ready);
	assign upd_valid = out_valid_q;
	assign upd       = out_q;

	// walk slots before the end-point result
	always_comb begin
		if (cfg.ray_slots == 7'd0)
			slots_m1 = 7'd0;
		else if (cfg.ray_slots > 7'(MAX_STEPS))
			slots_m1 = 7'(MAX_STEPS - 1);
		else
			slots_m1 = cfg.ray_slots - 7'd1;
	end

	assign at_end = (k_q == slots_m1[KW-1:0]);

	always_comb begin
		case (dom_q)
			AXIS_X: begin
				cur_dom = cur_q[0];
				end_dom = CUR_W'($signed(vend_q[0]));
				ad_dom  = ad_q[0];
			end
			AXIS_Y: begin
				cur_dom = cur_q[1];
				end_dom = CUR_W'($signed(vend_q[1]));
				ad_dom  = ad_q[1];
			end
			AXIS_Z: begin
				cur_dom = cur_q[2];
				end_dom = CUR_W'($signed(vend_q[2]));
				ad_dom  = ad_q[2];
			end
			default: begin
				cur_dom = cur_q[0];
				end_dom = CUR_W'($signed(vend_q[0]));
				ad_dom  = ad_q[0];
			end
		endcase
	end

	// zero end on the dominant axis counts as reached at once
	assign reached = ($signed(end_dom) > 0) ? ($signed(cur_dom) >= $signed(end_dom))
	                                        : ($signed(cur_dom) <= $signed(end_dom));

	always_comb begin
		logic [CUR_W-1:0] mag;
		cur_oor = 1'b0;
		for (int i = 0; i < 3; i++) begin
			mag = cur_q[i][CUR_W-1] ? (CUR_W'(0) - cur_q[i]) : cur_q[i];
			if (mag > CUR_W'(cfg.range_limit))
				cur_oor = 1'b1;
		end
		cur_oor = cur_oor && cfg.range_check_enable;
	end

	// one bresenham step
	always_comb begin
		logic [CUR_W-1:0] sgnv;
		for (int i = 0; i < 3; i++) begin
			if (vend_q[i][VOX_W-1])
				sgnv = '1;
			else if (vend_q[i] != '0)
				sgnv = CUR_W'(1);
			else
				sgnv = '0;
			if (2'(i) == dom_q) begin
				cur_d[i] = cur_q[i] + sgnv;
				err_d[i] = err_q[i];
			end else if (!err_q[i][ERR_W-1]) begin
				cur_d[i] = cur_q[i] + sgnv;
				err_d[i] = err_q[i] - ERR_W'(ad_dom) + ERR_W'(ad_q[i]);
			end else begin
				cur_d[i] = cur_q[i];
				err_d[i] = err_q[i] + ERR_W'(ad_q[i]);
			end
		end
	end

	always_comb begin
		res.voxel_x = cur_q[0][VOX_W-1:0];
		res.voxel_y = cur_q[1][VOX_W-1:0];
		res.voxel_z = cur_q[2][VOX_W-1:0];
		res.last    = 1'b0;
		if (at_end) begin
			emit                = 1'b1;
			res.voxel_x         = vend_q[0];
			res.voxel_y         = vend_q[1];
			res.voxel_z         = vend_q[2];
			res.log_odds_update = end_oor_q ? cfg.log_odds_unknown : cfg.log_odds_occupied;
			res.last            = 1'b1;
		end else if (reached) begin
			emit                = 1'b1;
			res.log_odds_update = cfg.log_odds_unknown;
		end else begin
			emit                = !cur_oor;
			res.log_odds_update = cfg.log_odds_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (adv) begin
				if (at_end)
					busy_q <= 1'b0;
				else if (emit)
					k_q <= k_q + 1'b1;
			end
			if (adv && emit)
				out_valid_q <= 1'b1;
			else if (upd_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vend_q    <= ray.vend;
			ad_q      <= ray.ad;
			err_q     <= ray.err;
			dom_q     <= ray.dom;
			end_oor_q <= ray.end_oor;
			cur_q     <= '0;
		end else if (adv && !at_end && !reached) begin
			cur_q <= cur_d;
			err_q <= err_d;
		end
		if (adv && emit)
			out_q <= res;
	end

`ifndef SYNTHESIS
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid_q && out_q.last)
		else $error("ray closed without end-point result");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && k_q == '0)
		else $error("ray load did not start a walk");
`endif

endmodule
`default_nettype wire

/* tb/voxel_ray_walk_log_odds_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_walk_log_odds_tb: self-checking bench of the voxel ray walker
// hit requests go in through a valid/ready sender and every update request
// that comes out is checked against a bit-exact bresenham walk kept in the
// bench; directed rays hit the corner cases, then random rays run under
// several idle and stall mixes and many register settings
// ----------------------------------------------------------------------------
module voxel_ray_walk_log_odds_tb;
	import vrw_pkg::*;

	localparam int WALK_SLOTS_MAX = 64;
	localparam int CYCLE_LIMIT    = 2000000;
	// settle time after the last update before a register write
	localparam int DRAIN_GAP      = 8;
	// quiet time at the end, after every owed update is out
	localparam int TAIL_CYCLES    = 2 * WALK_SLOTS_MAX + 16;
	localparam int PRINT_CAP      = 40;
	// index past the register file, writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  hit_valid   = 1'b0;
	logic                  hit_ready;
	hit_t                  hit         = '0;
	logic                  upd_valid;
	logic                  upd_ready   = 1'b0;
	upd_t                  upd;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// bench copy of the register file, follows every write
	cfg_t cfg_shadow;
	// updates the walker still owes, oldest first
	upd_t pending_upd_q [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_cnt   = 0;
	int hits_sent      = 0;
	int upds_checked   = 0;
	int cfg_settings   = 0;
	int cycle_cnt      = 0;

	voxel_ray_walk_log_odds #(
		.MAX_STEPS(WALK_SLOTS_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.hit_valid(hit_valid),
		.hit_ready(hit_ready),
		.hit      (hit),
		.upd_valid(upd_valid),
		.upd_ready(upd_ready),
		.upd      (upd),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// hard stop in case the walker hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d updates still owed", cycle_cnt,
				pending_upd_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP)
			$display("[%0t] %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// prediction: quantize, then walk the dominant axis one slot a time
	// ------------------------------------------------------------------

	// q15.8 meters times q8.8 voxels per meter, round half away from zero,
	// saturate to 16 bits
	function automatic int quantize_axis(input logic signed [23:0] raw);
		longint prod, mag, q;
		prod = longint'(raw) * longint'(cfg_shadow.inv_resolution);
		mag  = (prod < 0) ? -prod : prod;
		q    = (mag + 64'sd32768) >>> 16;
		if (prod >= 0)
			return (q > 32767) ? 32767 : int'(q);
		return (q > 32768) ? -32768 : -int'(q);
	endfunction

	// symmetric box test, only when range checking is on
	function automatic bit outside_range(input int c [3]);
		int i;
		if (!cfg_shadow.range_check_enable)
			return 1'b0;
		for (i = 0; i < 3; i++)
			if (((c[i] < 0) ? -c[i] : c[i]) > int'(cfg_shadow.range_limit))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void queue_update(input int c [3], input logic [15:0] lo,
		input bit is_last);
		upd_t u;
		u.voxel_x         = 16'(c[0]);
		u.voxel_y         = 16'(c[1]);
		u.voxel_z         = 16'(c[2]);
		u.log_odds_update = lo;
		u.last            = is_last;
		pending_upd_q.push_back(u);
	endfunction

	function automatic void walk_ray(input hit_t h);
		int fin [3];
		int cur [3];
		int ad [3];
		int dir [3];
		int err [3];
		int loc [3];
		int dom, slots, k, i;
		bit walking;
		logic [15:0] lo;
		// slot count clamps to 1..max
		slots = int'(cfg_shadow.ray_slots);
		if (slots < 1)
			slots = 1;
		if (slots > WALK_SLOTS_MAX)
			slots = WALK_SLOTS_MAX;
		fin[0] = quantize_axis(h.hit_x);
		fin[1] = quantize_axis(h.hit_y);
		fin[2] = quantize_axis(h.hit_z);
		// strict compare, so on a tie the lower axis keeps dominance
		dom = 0;
		for (i = 0; i < 3; i++) begin
			cur[i] = 0;
			ad[i]  = 2 * ((fin[i] < 0) ? -fin[i] : fin[i]);
			dir[i] = (fin[i] > 0) ? 1 : ((fin[i] < 0) ? -1 : 0);
			if (ad[i] > ad[dom])
				dom = i;
		end
		for (i = 0; i < 3; i++)
			err[i] = ad[i] - ad[dom] / 2;
		walking = 1'b1;
		k = 0;
		while (k < slots - 1) begin
			loc = cur;
			lo  = cfg_shadow.log_odds_unknown;
			// end reached along the dominant axis (origin hit stops at once)
			if ((dir[dom] > 0) ? (cur[dom] >= fin[dom]) : (cur[dom] <= fin[dom]))
				walking = 1'b0;
			if (walking) begin
				for (i = 0; i < 3; i++)
					if (i != dom && err[i] >= 0) begin
						cur[i] += dir[i];
						err[i] -= ad[dom];
					end
				for (i = 0; i < 3; i++)
					if (i == dom)
						cur[i] += dir[i];
					else
						err[i] += ad[i];
				lo = cfg_shadow.log_odds_free;
				// out-of-range walk voxel takes no slot
				if (outside_range(loc))
					continue;
			end
			queue_update(loc, lo, 1'b0);
			k++;
		end
		queue_update(fin, outside_range(fin) ? cfg_shadow.log_odds_unknown :
			cfg_shadow.log_odds_occupied, 1'b1);
	endfunction

	// ------------------------------------------------------------------
	// update side: random stalls, every accepted update checked in order
	// ------------------------------------------------------------------
	always @(posedge clk) begin : upd_monitor
		upd_t want;
		upd_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && upd_valid && upd_ready) begin
			upds_checked++;
			if (pending_upd_q.size() == 0) begin
				report_mismatch($sformatf("update (%0d,%0d,%0d) lo %0d last %0b with none owed",
					$signed(upd.voxel_x), $signed(upd.voxel_y), $signed(upd.voxel_z),
					$signed(upd.log_odds_update), upd.last));
			end else begin
				want = pending_upd_q.pop_front();
				if (upd.voxel_x !== want.voxel_x)
					report_mismatch($sformatf("voxel_x got %0d want %0d",
						$signed(upd.voxel_x), $signed(want.voxel_x)));
				if (upd.voxel_y !== want.voxel_y)
					report_mismatch($sformatf("voxel_y got %0d want %0d",
						$signed(upd.voxel_y), $signed(want.voxel_y)));
				if (upd.voxel_z !== want.voxel_z)
					report_mismatch($sformatf("voxel_z got %0d want %0d",
						$signed(upd.voxel_z), $signed(want.voxel_z)));
				if (upd.log_odds_update !== want.log_odds_update)
					report_mismatch($sformatf("log_odds_update got %0d want %0d",
						$signed(upd.log_odds_update), $signed(want.log_odds_update)));
				if (upd.last !== want.last)
					report_mismatch($sformatf("last got %0b want %0b", upd.last, want.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// hit side
	// ------------------------------------------------------------------

	// valid stays high across back-to-back requests; it only drops on an
	// idle cycle or when the bench waits for the walker to drain
	task automatic send_hit(input hit_t h);
		while ($urandom_range(99) < send_idle_pct) begin
			hit_valid <= 1'b0;
			@(posedge clk);
		end
		hit_valid <= 1'b1;
		hit       <= h;
		do
			@(posedge clk);
		while (!hit_ready);
		walk_ray(h);
		hits_sent++;
	endtask

	// hold off new hits until every owed update is out
	task automatic wait_drained();
		hit_valid <= 1'b0;
		while (pending_upd_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	function automatic hit_t mk_hit(input int x, input int y, input int z);
		hit_t h;
		h.hit_x = x[23:0];
		h.hit_y = y[23:0];
		h.hit_z = z[23:0];
		return h;
	endfunction

	// ------------------------------------------------------------------
	// register writes, only ever issued with the walker idle
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_INV_RES:   cfg_shadow.inv_resolution     = data;
			CFG_STEPS:     cfg_shadow.ray_slots          = data[6:0];
			CFG_RANGE_EN:  cfg_shadow.range_check_enable = data[0];
			CFG_RANGE_LIM: cfg_shadow.range_limit        = data[14:0];
			CFG_LO_FREE:   cfg_shadow.log_odds_free      = data;
			CFG_LO_OCC:    cfg_shadow.log_odds_occupied  = data;
			CFG_LO_UNK:    cfg_shadow.log_odds_unknown   = data;
			default: ;
		endcase
	endtask

	// every register in turn, then a write to the unmapped index
	task automatic program_cfg(input logic [15:0] inv, input logic [6:0] steps,
		input logic en, input logic [14:0] lim, input logic [15:0] lo_free,
		input logic [15:0] lo_occ, input logic [15:0] lo_unk);
		wait_drained();
		write_reg(CFG_INV_RES, inv);
		write_reg(CFG_STEPS, {9'($urandom), steps});
		write_reg(CFG_RANGE_EN, {15'($urandom), en});
		write_reg(CFG_RANGE_LIM, {1'($urandom), lim});
		write_reg(CFG_LO_FREE, lo_free);
		write_reg(CFG_LO_OCC, lo_occ);
		write_reg(CFG_LO_UNK, lo_unk);
		write_reg(CFG_SPARE, 16'($urandom));
		cfg_wr_en <= 1'b0;
		cfg_settings++;
	endtask

	task automatic randomize_cfg();
		logic [15:0] inv;
		logic [6:0]  steps;
		logic [14:0] lim;
		case ($urandom_range(0, 4))
			0: inv = 16'($urandom_range(1, 65535));
			1: inv = 16'd256;
			2: inv = RST_INV_RES;
			3: inv = 16'hFFFF;
			default: inv = 16'($urandom_range(1, 64));
		endcase
		case ($urandom_range(0, 7))
			0: steps = 7'($urandom_range(0, 1) ? 0 : $urandom_range(65, 127));
			1: steps = 7'd1;
			2: steps = 7'(WALK_SLOTS_MAX);
			default: steps = 7'($urandom_range(1, WALK_SLOTS_MAX));
		endcase
		case ($urandom_range(0, 3))
			0: lim = 15'($urandom_range(0, 63));
			1: lim = 15'($urandom_range(64, 32767));
			2: lim = 15'h7FFF;
			default: lim = 15'($urandom_range(0, 8));
		endcase
		program_cfg(inv, steps, 1'($urandom_range(0, 1)), lim, 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// raw q15.8 value that lands near voxel v at the current resolution
	function automatic longint voxel_to_raw(input int v);
		return (longint'(v) * 64'sd65536) / longint'(cfg_shadow.inv_resolution);
	endfunction

	// keep_short: tight range box, so rays stay short to bound the skip time
	function automatic hit_t rand_hit(input bit keep_short);
		longint raw [3];
		int mode, v, j, i, sgn;
		logic [2:0] tie_mask;
		hit_t h;
		mode = keep_short ? $urandom_range(1, 2) : $urandom_range(0, 3);
		v    = $urandom_range(0, 80);
		case ($urandom_range(0, 3))
			0: tie_mask = 3'b011;
			1: tie_mask = 3'b101;
			2: tie_mask = 3'b110;
			default: tie_mask = 3'b111;
		endcase
		for (i = 0; i < 3; i++) begin
			sgn = $urandom_range(0, 1) ? -1 : 1;
			case (mode)
				// any 24-bit value, mostly saturating
				0: raw[i] = longint'($signed(24'($urandom)));
				// end voxel close to the origin, walk completes and pads
				1: begin
					j = $urandom_range(0, 160);
					raw[i] = voxel_to_raw(j - 80);
					j = $urandom_range(0, 16);
					raw[i] = raw[i] + j - 8;
				end
				// equal magnitudes on two or three axes
				2: begin
					j = tie_mask[i] ? v : $urandom_range(0, v);
					raw[i] = voxel_to_raw(j * sgn);
				end
				// far end, walk cut short by the slot count
				default: begin
					j = $urandom_range(0, 4000);
					raw[i] = voxel_to_raw(j - 2000);
				end
			endcase
			if (raw[i] > 64'sd8388607)
				raw[i] = 64'sd8388607;
			if (raw[i] < -64'sd8388608)
				raw[i] = -64'sd8388608;
		end
		h.hit_x = 24'(raw[0]);
		h.hit_y = 24'(raw[1]);
		h.hit_z = 24'(raw[2]);
		return h;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// registers left at reset: origin, ties, saturation both ways
	task automatic test_reset_config();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_hit(mk_hit(0, 0, 0));
		send_hit(mk_hit(256, 0, 0));
		send_hit(mk_hit(512, 512, 512));
		// y and z tie above x, y keeps dominance
		send_hit(mk_hit(256, 512, 512));
		send_hit(mk_hit(8388607, 8388607, 8388607));
		send_hit(mk_hit(-8388608, -8388608, -8388608));
		wait_drained();
	endtask

	// rounding at the half point and saturation at the resolution extremes
	task automatic test_quantization();
		program_cfg(16'd256, 7'd64, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(128, -128, 127));
		send_hit(mk_hit(384, -384, 0));
		program_cfg(16'hFFFF, 7'd64, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(8388607, -8388608, 1));
		send_hit(mk_hit(1, -1, 0));
		program_cfg(16'd1, 7'd64, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(32768, -32767, 8388607));
		send_hit(mk_hit(-8388608, 8388607, -32768));
		wait_drained();
	endtask

	// slot count: single end result, zero and oversize clamps, two slots
	task automatic test_slot_counts();
		send_idle_pct  = 16;
		recv_stall_pct = 16;
		program_cfg(RST_INV_RES, 7'd1, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(1280, 768, -512));
		send_hit(mk_hit(0, 0, 0));
		program_cfg(RST_INV_RES, 7'd0, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(1280, 768, -512));
		program_cfg(RST_INV_RES, 7'd127, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC,
			RST_LO_UNK);
		send_hit(mk_hit(-1280, 768, 512));
		program_cfg(RST_INV_RES, 7'd2, 1'b0, 15'h7FFF, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(-1280, -768, 512));
		wait_drained();
	endtask

	// range box: skipped walk voxels, out-of-range end, zero box, extreme odds
	task automatic test_range_check();
		program_cfg(RST_INV_RES, 7'd64, 1'b1, 15'd3, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(512, 256, 0));
		// -32768 exceeds even the widest box
		program_cfg(RST_INV_RES, 7'd64, 1'b1, 15'h7FFF, RST_LO_FREE, RST_LO_OCC,
			RST_LO_UNK);
		send_hit(mk_hit(-8388608, 0, 256));
		program_cfg(RST_INV_RES, 7'd8, 1'b1, 15'd0, RST_LO_FREE, RST_LO_OCC, RST_LO_UNK);
		send_hit(mk_hit(0, 0, 0));
		// one long ray: every walk voxel between the origin and the end is skipped
		send_hit(mk_hit(8388607, 4096, -2048));
		program_cfg(RST_INV_RES, 7'd16, 1'b0, 15'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
		send_hit(mk_hit(768, -768, 256));
		wait_drained();
	endtask

	// random rays in four idle/stall mixes; each new setting drains first
	task automatic test_random_traffic();
		int idle_set [4];
		int stall_set [4];
		int ph, n;
		bit keep_short;
		idle_set  = '{0, 72, 0, 16};
		stall_set = '{0, 0, 72, 16};
		keep_short = 1'b0;
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_set[ph];
			recv_stall_pct = stall_set[ph];
			for (n = 0; n < 112; n++) begin
				if (n % 28 == 0) begin
					randomize_cfg();
					keep_short = cfg_shadow.range_check_enable &&
						(cfg_shadow.range_limit < 15'(WALK_SLOTS_MAX));
				end
				send_hit(rand_hit(keep_short));
			end
		end
		wait_drained();
	endtask

	initial begin
		cfg_shadow = '{inv_resolution: RST_INV_RES, ray_slots: RST_STEPS,
			range_check_enable: RST_RANGE_EN, range_limit: RST_RANGE_LIM,
			log_odds_free: RST_LO_FREE, log_odds_occupied: RST_LO_OCC,
			log_odds_unknown: RST_LO_UNK};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_quantization();
		test_slot_counts();
		test_range_check();
		test_random_traffic();

		// anything arriving now is a stray update
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d hits, %0d updates compared, %0d register settings, %0d cycles",
			hits_sent, upds_checked, cfg_settings, cycle_cnt);
		$display("covered rounding, saturation, axis ties, slot clamps, range skips, stalls");
		if (mismatch_cnt == 0 && pending_upd_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d errors, %0d updates never arrived", mismatch_cnt,
				pending_upd_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* voxel_ray_walk_log_odds.f */
rtl/vrw_pkg.sv
rtl/vrw_front.sv
rtl/vrw_fifo.sv
rtl/vrw_back.sv
rtl/voxel_ray_walk_log_odds.sv
tb/voxel_ray_walk_log_odds_tb.sv
